@@ hw/rtl/drt_pkg.sv @@
// Package for the divider and reload timer: widths, periods, sequencer codes
// and the microcode table.
// No dependencies; used by divider_and_reload_timer_core.
package drt_pkg;

	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned DIV_PRE_W  = 10;
	localparam int unsigned CNT_PRE_W  = 11;
	localparam int unsigned SEL_W      = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned OUT_DATA_W = 24;
	localparam int unsigned OUT_PAD_W  = OUT_DATA_W - 2 * BYTE_W - 1;

	localparam logic [CNT_PRE_W-1:0] DIV_PERIOD = CNT_PRE_W'(256);
	localparam logic [CNT_PRE_W-1:0] PERIOD_00  = CNT_PRE_W'(1024);
	localparam logic [CNT_PRE_W-1:0] PERIOD_01  = CNT_PRE_W'(16);
	localparam logic [CNT_PRE_W-1:0] PERIOD_10  = CNT_PRE_W'(64);
	localparam logic [CNT_PRE_W-1:0] PERIOD_11  = CNT_PRE_W'(256);

	localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELOAD = 2'd2;

	// Input operation codes
	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_DIV_WRITE = 1'b1;

	// Sequencer step addresses
	localparam int unsigned STEP_W = 3;
	localparam logic [STEP_W-1:0] STEP_FETCH    = 3'd0;
	localparam logic [STEP_W-1:0] STEP_DISPATCH = 3'd1;
	localparam logic [STEP_W-1:0] STEP_ACCUM    = 3'd2;
	localparam logic [STEP_W-1:0] STEP_DIV_LOOP = 3'd3;
	localparam logic [STEP_W-1:0] STEP_CNT_LOOP = 3'd4;
	localparam logic [STEP_W-1:0] STEP_DIV_WR   = 3'd5;
	localparam logic [STEP_W-1:0] STEP_DONE     = 3'd6;
	localparam logic [STEP_W-1:0] STEP_SPARE    = 3'd7;

	// Branch conditions
	localparam int unsigned COND_W = 3;
	localparam logic [COND_W-1:0] C_ALWAYS   = 3'd0;
	localparam logic [COND_W-1:0] C_IN_VALID = 3'd1;
	localparam logic [COND_W-1:0] C_OP_WRITE = 3'd2;
	localparam logic [COND_W-1:0] C_ENABLED  = 3'd3;
	localparam logic [COND_W-1:0] C_DIV_DUE  = 3'd4;
	localparam logic [COND_W-1:0] C_CNT_DUE  = 3'd5;
	localparam logic [COND_W-1:0] C_OUT_FREE = 3'd6;

	// Datapath actions, performed only when the step's condition holds
	localparam int unsigned ACT_W = 3;
	localparam logic [ACT_W-1:0] A_NOP       = 3'd0;
	localparam logic [ACT_W-1:0] A_LOAD      = 3'd1;
	localparam logic [ACT_W-1:0] A_ADD       = 3'd2;
	localparam logic [ACT_W-1:0] A_DIV_STEP  = 3'd3;
	localparam logic [ACT_W-1:0] A_CNT_STEP  = 3'd4;
	localparam logic [ACT_W-1:0] A_DIV_WRITE = 3'd5;
	localparam logic [ACT_W-1:0] A_EMIT      = 3'd6;

	typedef struct packed {
		logic [COND_W-1:0] cond;
		logic [ACT_W-1:0]  act;
		logic [STEP_W-1:0] next_true;
		logic [STEP_W-1:0] next_false;
	} ucode_word_t;

	function automatic ucode_word_t ucode_rom(input logic [STEP_W-1:0] step);
		ucode_word_t w;
		unique case (step)
			STEP_FETCH:    w = '{C_IN_VALID, A_LOAD,      STEP_DISPATCH, STEP_FETCH};
			STEP_DISPATCH: w = '{C_OP_WRITE, A_NOP,       STEP_DIV_WR,   STEP_ACCUM};
			STEP_ACCUM:    w = '{C_ENABLED,  A_ADD,       STEP_DIV_LOOP, STEP_DONE};
			STEP_DIV_LOOP: w = '{C_DIV_DUE,  A_DIV_STEP,  STEP_DIV_LOOP, STEP_CNT_LOOP};
			STEP_CNT_LOOP: w = '{C_CNT_DUE,  A_CNT_STEP,  STEP_CNT_LOOP, STEP_DONE};
			STEP_DIV_WR:   w = '{C_ALWAYS,   A_DIV_WRITE, STEP_DONE,     STEP_DONE};
			STEP_DONE:     w = '{C_OUT_FREE, A_EMIT,      STEP_FETCH,    STEP_DONE};
			default:       w = '{C_ALWAYS,   A_NOP,       STEP_FETCH,    STEP_FETCH};
		endcase
		return w;
	endfunction

	function automatic logic [CNT_PRE_W-1:0] period_of(input logic [SEL_W-1:0] sel);
		logic [CNT_PRE_W-1:0] p;
		unique case (sel)
			2'd0:    p = PERIOD_00;
			2'd1:    p = PERIOD_01;
			2'd2:    p = PERIOD_10;
			default: p = PERIOD_11;
		endcase
		return p;
	endfunction

endpackage

@@ hw/rtl/divider_and_reload_timer_core.sv @@
// Divider and reload timer: a microcoded sequencer over a small datapath.
// Uses drt_pkg for widths, periods, sequencer codes and the microcode table.
//
// Each transaction on the input stream advances the timer by a number of
// machine cycles, or (tuser high) writes the divider, which clears it and
// reloads the timer counter. Exactly one result transaction follows each
// input: divider, counter and an interrupt flag that is set when the counter
// passed 255 and reloaded at least once. A divider write runs fetch, dispatch,
// divider write and done; a disabled timer runs fetch, dispatch, accumulate
// and done; an advance adds the divider and counter step loops before done,
// one pass for each prescaler expiry, so a short period (or a period changed
// to a smaller one) lengthens the item. The next input is taken once the
// result has been placed in the output register. Configuration writes go
// straight to the registers and are seen by an item already in progress.
module divider_and_reload_timer_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// Configuration write port
	input  logic                               cfg_we,
	input  logic [drt_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [drt_pkg::BYTE_W-1:0]         cfg_data,
	// Input stream
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [drt_pkg::BYTE_W-1:0]         s_tdata,  // [7:0] cycles
	input  logic                               s_tuser,  // [0] operation
	// Output stream
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [7:0] divider_value, [15:8] counter_value, [16] interrupt_request, rest 0
	output logic [drt_pkg::OUT_DATA_W-1:0]     m_tdata
);
	import drt_pkg::*;

	logic                 enable_q;
	logic [SEL_W-1:0]     select_q;
	logic [BYTE_W-1:0]    reload_q;

	logic [STEP_W-1:0]    pc_q;
	logic                 op_q;
	logic [BYTE_W-1:0]    cycles_q;
	logic                 irq_q;

	logic [DIV_PRE_W-1:0] div_pre_q;
	logic [CNT_PRE_W-1:0] cnt_pre_q;
	logic [BYTE_W-1:0]    div_q;
	logic [BYTE_W-1:0]    cnt_q;

	logic                 out_valid_q;
	logic [BYTE_W-1:0]    out_div_q;
	logic [BYTE_W-1:0]    out_cnt_q;
	logic                 out_irq_q;

	ucode_word_t          uw;
	logic                 cond_ok;
	logic                 out_free;
	logic [CNT_PRE_W-1:0] period;
	logic [CNT_PRE_W-1:0] div_pre_ext;

	assign uw          = ucode_rom(pc_q);
	assign out_free    = !out_valid_q || m_tready;
	assign period      = period_of(select_q);
	assign div_pre_ext = {{(CNT_PRE_W - DIV_PRE_W){1'b0}}, div_pre_q};

	always_comb begin
		unique case (uw.cond)
			C_ALWAYS:   cond_ok = 1'b1;
			C_IN_VALID: cond_ok = s_tvalid;
			C_OP_WRITE: cond_ok = (op_q == OP_DIV_WRITE);
			C_ENABLED:  cond_ok = enable_q;
			C_DIV_DUE:  cond_ok = (div_pre_ext >= DIV_PERIOD);
			C_CNT_DUE:  cond_ok = (cnt_pre_q >= period);
			C_OUT_FREE: cond_ok = out_free;
			default:    cond_ok = 1'b0;
		endcase
	end

	assign s_tready = (pc_q == STEP_FETCH);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_irq_q, out_cnt_q, out_div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b0;
			select_q <= '0;
			reload_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ENABLE: enable_q <= cfg_data[0];
				REG_SELECT: select_q <= cfg_data[SEL_W-1:0];
				REG_RELOAD: reload_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= STEP_FETCH;
		end else begin
			pc_q <= cond_ok ? uw.next_true : uw.next_false;
		end
	end

	// Timer state and the per-item working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_pre_q <= '0;
			cnt_pre_q <= '0;
			div_q     <= '0;
			cnt_q     <= '0;
			irq_q     <= 1'b0;
		end else if (cond_ok) begin
			unique case (uw.act)
				A_NOP:  ;
				A_LOAD: irq_q <= 1'b0;
				A_ADD: begin
					div_pre_q <= DIV_PRE_W'(div_pre_ext + {3'b000, cycles_q});
					cnt_pre_q <= cnt_pre_q + {3'b000, cycles_q};
				end
				A_DIV_STEP: begin
					div_pre_q <= DIV_PRE_W'(div_pre_ext - DIV_PERIOD);
					div_q     <= div_q + 8'd1;
				end
				A_CNT_STEP: begin
					cnt_pre_q <= cnt_pre_q - period;
					if (cnt_q == BYTE_MAX) begin
						cnt_q <= reload_q;
						irq_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				A_DIV_WRITE: begin
					div_q <= '0;
					cnt_q <= reload_q;
				end
				A_EMIT: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_q     <= s_tuser;
			cycles_q <= s_tdata;
		end
	end

	// Output register: a result waits here while the next item is fetched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cond_ok && uw.act == A_EMIT) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cond_ok && uw.act == A_EMIT) begin
			out_div_q <= div_q;
			out_cnt_q <= cnt_q;
			out_irq_q <= irq_q;
		end
	end

	// The divider leftover is always below its period between items.
	a_div_pre_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_FETCH) |-> (div_pre_ext < DIV_PERIOD))
		else $error("divider prescaler not reduced below its period");

	// A result appears only as the sequencer leaves its final step.
	a_emit_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(pc_q) == STEP_DONE))
		else $error("result raised outside the final step");

	// A divider write never carries an interrupt.
	a_write_no_irq: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_DONE && op_q == OP_DIV_WRITE) |-> !irq_q)
		else $error("interrupt flagged on a divider write");

	// The sequencer holds at the final step while the output register is full.
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_DONE && !out_free) |=> (pc_q == STEP_DONE))
		else $error("sequencer left the final step with the output full");

	// The sequencer only fetches after the result has been written.
	a_fetch_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == STEP_DONE && out_free) |=> (out_valid_q && pc_q == STEP_FETCH))
		else $error("result not registered on leaving the final step");

endmodule
